// ----- rtl/kst_pkg.sv -----
`default_nettype none

package kst_pkg;

  localparam int unsigned SCORE_W = 32;

  typedef enum logic [1:0] {
    CMD_UPSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

// ----- rtl/kst_in_if.sv -----
`default_nettype none

interface kst_in_if #(
  parameter int unsigned ID_W   = 16,
  parameter int unsigned RANK_W = 6
);

  logic                               valid;
  logic                               ready;
  kst_pkg::cmd_e                      command;
  logic [ID_W-1:0]                    neighbor_id;
  logic signed [kst_pkg::SCORE_W-1:0] score;
  logic [RANK_W-1:0]                  rank_index;

  modport source (
    output valid, command, neighbor_id, score, rank_index,
    input  ready
  );

  modport sink (
    input  valid, command, neighbor_id, score, rank_index,
    output ready
  );

endinterface

`default_nettype wire

// ----- rtl/kst_out_if.sv -----
`default_nettype none

interface kst_out_if #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned CNT_W = 7
);

  logic                               valid;
  logic                               ready;
  logic [CNT_W-1:0]                   position;
  logic [CNT_W-1:0]                   entry_count;
  logic                               was_present;
  logic                               table_full;
  logic [ID_W-1:0]                    read_id;
  logic signed [kst_pkg::SCORE_W-1:0] read_score;
  logic                               read_valid;

  modport source (
    output valid, position, entry_count, was_present, table_full,
           read_id, read_score, read_valid,
    input  ready
  );

  modport sink (
    input  valid, position, entry_count, was_present, table_full,
           read_id, read_score, read_valid,
    output ready
  );

endinterface

`default_nettype wire

// ----- rtl/kst_ram.sv -----
`default_nettype none

module kst_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 48,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/keyed_sorted_score_table.sv -----
// upsert and remove scan the stored entries, then move the entries that lie between the old
// and the new position; an upsert then writes its entry, a miss on remove or a dropped upsert
// moves nothing; read looks up one ram word. one request in work at a time, the next is taken
// in the cycle after a result is loaded, also while it waits in the output register
// reset clears the entry count and handshake state; ram words are read only below the entry
// count, but for a read past it, whose data is not returned
`default_nettype none

module keyed_sorted_score_table #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kst_in_if.sink    in_i,
  kst_out_if.source out_o
);

  localparam int unsigned RANK_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = ID_BITS + kst_pkg::SCORE_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_INSERT,
    ST_READ,
    ST_DONE
  } state_e;

  state_e                             state_q, state_d;
  kst_pkg::cmd_e                      cmd_q, cmd_d;
  logic [ID_BITS-1:0]                 key_q, key_d;
  logic signed [kst_pkg::SCORE_W-1:0] score_q, score_d;
  logic [RANK_W-1:0]                  rank_q, rank_d;
  logic [CNT_W-1:0]                   count_q, count_d;
  logic [CNT_W-1:0]                   scan_ptr_q, scan_ptr_d;
  logic                               cmp_pend_q, cmp_pend_d;
  logic [RANK_W-1:0]                  cmp_idx_q, cmp_idx_d;
  logic                               found_q, found_d;
  logic [RANK_W-1:0]                  found_idx_q, found_idx_d;
  logic [CNT_W-1:0]                   ge_cnt_q, ge_cnt_d;
  logic                               left_q, left_d;
  logic [CNT_W-1:0]                   ptr_q, ptr_d;
  logic [CNT_W-1:0]                   remain_q, remain_d;
  logic                               wr_pend_q, wr_pend_d;
  logic [RANK_W-1:0]                  wr_addr_q, wr_addr_d;
  logic                               ins_q, ins_d;
  logic [CNT_W-1:0]                   pos_q, pos_d;
  logic                               full_q, full_d;

  logic                               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]                   res_pos_q, res_pos_d;
  logic [CNT_W-1:0]                   res_count_q, res_count_d;
  logic                               res_present_q, res_present_d;
  logic                               res_full_q, res_full_d;
  logic [ID_BITS-1:0]                 res_id_q, res_id_d;
  logic signed [kst_pkg::SCORE_W-1:0] res_score_q, res_score_d;
  logic                               res_rvalid_q, res_rvalid_d;

  logic                               rd_en, wr_en;
  logic [RANK_W-1:0]                  rd_addr, wr_addr;
  logic [ENTRY_W-1:0]                 rd_data, wr_data;
  logic [ID_BITS-1:0]                 rd_id;
  logic signed [kst_pkg::SCORE_W-1:0] rd_score;
  logic                               id_hit, score_ge;

  kst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // shared compare unit: key match and signed score order
  assign rd_id    = rd_data[ENTRY_W-1 -: ID_BITS];
  assign rd_score = $signed(rd_data[kst_pkg::SCORE_W-1:0]);
  assign id_hit   = (rd_id == key_q);
  assign score_ge = (rd_score >= score_q);

  always_comb begin
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic             go_left;
    logic             go_shift;
    logic [CNT_W-1:0] f_pos;
    logic [CNT_W-1:0] ptr_up;
    logic [CNT_W-1:0] ptr_dn;
    logic             scan_more;
    logic             rank_ok;

    state_d       = state_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    score_d       = score_q;
    rank_d        = rank_q;
    count_d       = count_q;
    scan_ptr_d    = scan_ptr_q;
    cmp_pend_d    = cmp_pend_q;
    cmp_idx_d     = cmp_idx_q;
    found_d       = found_q;
    found_idx_d   = found_idx_q;
    ge_cnt_d      = ge_cnt_q;
    left_d        = left_q;
    ptr_d         = ptr_q;
    remain_d      = remain_q;
    wr_pend_d     = wr_pend_q;
    wr_addr_d     = wr_addr_q;
    ins_d         = ins_q;
    pos_d         = pos_q;
    full_d        = full_q;
    out_valid_d   = out_valid_q;
    res_pos_d     = res_pos_q;
    res_count_d   = res_count_q;
    res_present_d = res_present_q;
    res_full_d    = res_full_q;
    res_id_d      = res_id_q;
    res_score_d   = res_score_q;
    res_rvalid_d  = res_rvalid_q;

    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    lo        = '0;
    hi        = '0;
    go_left   = 1'b0;
    go_shift  = 1'b0;
    f_pos     = CNT_W'(found_idx_q);
    ptr_up    = ptr_q + 1'b1;
    ptr_dn    = ptr_q - 1'b1;
    scan_more = (scan_ptr_q < count_q);
    rank_ok   = (CNT_W'(rank_q) < count_q);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d      = in_i.command;
          key_d      = in_i.neighbor_id;
          score_d    = in_i.score;
          rank_d     = in_i.rank_index;
          scan_ptr_d = '0;
          cmp_pend_d = 1'b0;
          found_d    = 1'b0;
          ge_cnt_d   = '0;
          ins_d      = 1'b0;
          full_d     = 1'b0;
          pos_d      = CAP_C;
          unique case (in_i.command) inside
            kst_pkg::CMD_UPSERT, kst_pkg::CMD_REMOVE: state_d = ST_SCAN;
            kst_pkg::CMD_READ:                        state_d = ST_READ;
            default:                                  state_d = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        // read one entry a cycle, compare it the cycle after
        if (scan_more) begin
          rd_en      = 1'b1;
          rd_addr    = scan_ptr_q[RANK_W-1:0];
          scan_ptr_d = scan_ptr_q + 1'b1;
        end
        cmp_pend_d = scan_more;
        cmp_idx_d  = scan_ptr_q[RANK_W-1:0];
        if (cmp_pend_q) begin
          if (id_hit && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = cmp_idx_q;
          end
          // the entry being replaced does not count toward the new rank
          if (score_ge && !id_hit) begin
            ge_cnt_d = ge_cnt_q + 1'b1;
          end
        end
        if (!scan_more && !cmp_pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_DONE;
        unique case (cmd_q)
          kst_pkg::CMD_UPSERT: begin
            if (found_q) begin
              go_shift = 1'b1;
              ins_d    = 1'b1;
              pos_d    = ge_cnt_q;
              if (ge_cnt_q >= f_pos) begin
                go_left = 1'b1;
                lo      = f_pos;
                hi      = ge_cnt_q;
              end else begin
                lo = ge_cnt_q;
                hi = f_pos;
              end
            end else if (count_q == CAP_C) begin
              full_d = 1'b1;
            end else begin
              go_shift = 1'b1;
              ins_d    = 1'b1;
              pos_d    = ge_cnt_q;
              lo       = ge_cnt_q;
              hi       = count_q;
              count_d  = count_q + 1'b1;
            end
          end
          kst_pkg::CMD_REMOVE: begin
            if (found_q) begin
              go_shift = 1'b1;
              go_left  = 1'b1;
              lo       = f_pos;
              hi       = count_q - 1'b1;
              count_d  = count_q - 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (go_shift) begin
          state_d   = ST_SHIFT;
          left_d    = go_left;
          ptr_d     = go_left ? lo + 1'b1 : hi - 1'b1;
          remain_d  = hi - lo;
          wr_pend_d = 1'b0;
        end
      end

      ST_SHIFT: begin
        // left moves walk up, right moves walk down, so no word is overwritten unread
        if (wr_pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wr_addr_q;
          wr_data = rd_data;
        end
        if (remain_q != '0) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_q[RANK_W-1:0];
          ptr_d     = left_q ? ptr_up : ptr_dn;
          remain_d  = remain_q - 1'b1;
          wr_pend_d = 1'b1;
          wr_addr_d = left_q ? ptr_dn[RANK_W-1:0] : ptr_up[RANK_W-1:0];
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            state_d = ins_q ? ST_INSERT : ST_DONE;
          end
        end
      end

      ST_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[RANK_W-1:0];
        wr_data = {key_q, score_q};
        state_d = ST_DONE;
      end

      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = rank_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          res_pos_d     = pos_q;
          res_count_d   = count_q;
          res_present_d = found_q;
          res_full_d    = full_q;
          if (cmd_q == kst_pkg::CMD_READ && rank_ok) begin
            res_id_d     = rd_id;
            res_score_d  = rd_score;
            res_rvalid_d = 1'b1;
          end else begin
            res_id_d     = '0;
            res_score_d  = '0;
            res_rvalid_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cmd_q         <= kst_pkg::CMD_UPSERT;
      key_q         <= '0;
      score_q       <= '0;
      rank_q        <= '0;
      count_q       <= '0;
      scan_ptr_q    <= '0;
      cmp_pend_q    <= 1'b0;
      cmp_idx_q     <= '0;
      found_q       <= 1'b0;
      found_idx_q   <= '0;
      ge_cnt_q      <= '0;
      left_q        <= 1'b0;
      ptr_q         <= '0;
      remain_q      <= '0;
      wr_pend_q     <= 1'b0;
      wr_addr_q     <= '0;
      ins_q         <= 1'b0;
      pos_q         <= '0;
      full_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      res_pos_q     <= '0;
      res_count_q   <= '0;
      res_present_q <= 1'b0;
      res_full_q    <= 1'b0;
      res_id_q      <= '0;
      res_score_q   <= '0;
      res_rvalid_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      cmd_q         <= cmd_d;
      key_q         <= key_d;
      score_q       <= score_d;
      rank_q        <= rank_d;
      count_q       <= count_d;
      scan_ptr_q    <= scan_ptr_d;
      cmp_pend_q    <= cmp_pend_d;
      cmp_idx_q     <= cmp_idx_d;
      found_q       <= found_d;
      found_idx_q   <= found_idx_d;
      ge_cnt_q      <= ge_cnt_d;
      left_q        <= left_d;
      ptr_q         <= ptr_d;
      remain_q      <= remain_d;
      wr_pend_q     <= wr_pend_d;
      wr_addr_q     <= wr_addr_d;
      ins_q         <= ins_d;
      pos_q         <= pos_d;
      full_q        <= full_d;
      out_valid_q   <= out_valid_d;
      res_pos_q     <= res_pos_d;
      res_count_q   <= res_count_d;
      res_present_q <= res_present_d;
      res_full_q    <= res_full_d;
      res_id_q      <= res_id_d;
      res_score_q   <= res_score_d;
      res_rvalid_q  <= res_rvalid_d;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.position    = res_pos_q;
  assign out_o.entry_count = res_count_q;
  assign out_o.was_present = res_present_q;
  assign out_o.table_full  = res_full_q;
  assign out_o.read_id     = res_id_q;
  assign out_o.read_score  = res_score_q;
  assign out_o.read_valid  = res_rvalid_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CAP        = 64;
  localparam int ID_W       = 16;
  localparam int RANK_W     = 6;
  localparam int CNT_W      = 7;
  localparam int SCORE_W    = kst_pkg::SCORE_W;
  localparam int RAND_ITEMS = 1950;
  localparam int POOL_SPAN  = 72;
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_CYC  = 2 * CAP + 20;

  typedef struct packed {
    kst_pkg::cmd_e             cmd;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_W-1:0]         rank;
  } table_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]          position;
    logic [CNT_W-1:0]          entry_count;
    logic                      was_present;
    logic                      table_full;
    logic [ID_W-1:0]           read_id;
    logic signed [SCORE_W-1:0] read_score;
    logic                      read_valid;
  } table_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kst_in_if  #(.ID_W(ID_W), .RANK_W(RANK_W)) req_if ();
  kst_out_if #(.ID_W(ID_W), .CNT_W(CNT_W))   rsp_if ();

  keyed_sorted_score_table #(
    .CAPACITY(CAP),
    .ID_BITS (ID_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the score table, sorted by descending score
  logic [ID_W-1:0]           tbl_ids    [CAP];
  logic signed [SCORE_W-1:0] tbl_scores [CAP];
  int                        tbl_count = 0;

  table_req_t  pending_reqs [$];
  table_rsp_t  expected_rsps [$];
  table_req_t  cur_req;
  table_rsp_t  got_rsp;
  table_rsp_t  want_rsp;
  int unsigned err_count = 0;
  int unsigned queued    = 0;
  int unsigned cycle_no  = 0;
  logic [ID_W-1:0] pool_base;

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // no idling at all inside a fixed window of the run
  function automatic bit take_break();
    if (cycle_no >= 40000 && cycle_no < 90000) return 1'b0;
    return $urandom_range(0, 99) < 27;
  endfunction

  function automatic table_rsp_t apply_request(table_req_t r);
    table_rsp_t o;
    int slot;
    o = '0;
    o.position = CNT_W'(CAP);
    if (r.cmd == kst_pkg::CMD_UPSERT || r.cmd == kst_pkg::CMD_REMOVE) begin
      slot = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (slot < 0 && tbl_ids[i] == r.id) slot = i;
      end
      if (slot >= 0) begin
        o.was_present = 1'b1;
        for (int i = slot; i < tbl_count - 1; i++) begin
          tbl_ids[i]    = tbl_ids[i+1];
          tbl_scores[i] = tbl_scores[i+1];
        end
        tbl_count--;
      end
    end
    if (r.cmd == kst_pkg::CMD_UPSERT) begin
      if (tbl_count >= CAP) begin
        o.table_full = 1'b1;
      end else begin
        // new entry goes after every entry with a greater or equal score
        slot = 0;
        while (slot < tbl_count && $signed(tbl_scores[slot]) >= $signed(r.score)) slot++;
        for (int i = tbl_count; i > slot; i--) begin
          tbl_ids[i]    = tbl_ids[i-1];
          tbl_scores[i] = tbl_scores[i-1];
        end
        tbl_ids[slot]    = r.id;
        tbl_scores[slot] = r.score;
        tbl_count++;
        o.position = CNT_W'(slot);
      end
    end else if (r.cmd == kst_pkg::CMD_READ && int'(r.rank) < tbl_count) begin
      o.read_valid = 1'b1;
      o.read_id    = tbl_ids[r.rank];
      o.read_score = tbl_scores[r.rank];
    end
    o.entry_count = CNT_W'(tbl_count);
    return o;
  endfunction

  function automatic string rsp_text(table_rsp_t r);
    return $sformatf("pos=%0d cnt=%0d present=%0b full=%0b rd_id=%h rd_score=%h rd_valid=%0b",
                     r.position, r.entry_count, r.was_present, r.table_full,
                     r.read_id, r.read_score, r.read_valid);
  endfunction

  task automatic queue_req(kst_pkg::cmd_e c, logic [ID_W-1:0] id,
                           logic signed [SCORE_W-1:0] sc, logic [RANK_W-1:0] rk);
    table_req_t req;
    req = '{cmd: c, id: id, score: sc, rank: rk};
    pending_reqs.insert(pending_reqs.size(), req);
    queued++;
  endtask

  function automatic logic [ID_W-1:0] pool_id();
    return pool_base + ID_W'($urandom_range(0, POOL_SPAN - 1));
  endfunction

  // extremes, a few tied values and random scores so equal scores show up often
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return SCORE_W'((int'($urandom_range(0, 4)) - 2) * 65536);
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  // driver: one request at a time from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.insert(expected_rsps.size(), apply_request(cur_req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          cur_req             = pending_reqs.pop_front();
          req_if.valid       <= 1'b1;
          req_if.command     <= cur_req.cmd;
          req_if.neighbor_id <= cur_req.id;
          req_if.score       <= cur_req.score;
          req_if.rank_index  <= cur_req.rank;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results must come back in request order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !take_break();
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp = '{position: rsp_if.position, entry_count: rsp_if.entry_count,
                    was_present: rsp_if.was_present, table_full: rsp_if.table_full,
                    read_id: rsp_if.read_id, read_score: rsp_if.read_score,
                    read_valid: rsp_if.read_valid};
        if (expected_rsps.size() == 0) begin
          err_count++;
          if (err_count <= MAX_SHOWN) $display("unexpected result: %s", rsp_text(got_rsp));
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (got_rsp.position    !== want_rsp.position    ||
              got_rsp.entry_count !== want_rsp.entry_count ||
              got_rsp.was_present !== want_rsp.was_present ||
              got_rsp.table_full  !== want_rsp.table_full  ||
              got_rsp.read_id     !== want_rsp.read_id     ||
              got_rsp.read_score  !== want_rsp.read_score  ||
              got_rsp.read_valid  !== want_rsp.read_valid) begin
            err_count++;
            if (err_count <= MAX_SHOWN) begin
              $display("mismatch at %0t\n  expected %s\n  actual   %s",
                       $realtime, rsp_text(want_rsp), rsp_text(got_rsp));
            end
          end
        end
      end
    end
  end

  initial begin
    int pick;
    int seg_len;
    int directed;
    logic [ID_W-1:0] id;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = kst_pkg::CMD_UPSERT;
    req_if.neighbor_id = '0;
    req_if.score       = '0;
    req_if.rank_index  = '0;
    rsp_if.ready       = 1'b0;

    // empty table: read and remove find nothing
    queue_req(kst_pkg::CMD_READ,   16'h0000, 32'sh0, 6'd0);
    queue_req(kst_pkg::CMD_REMOVE, 16'h0000, 32'sh0, 6'd0);
    // extremes of id and score
    queue_req(kst_pkg::CMD_UPSERT, 16'h0000, 32'sh7FFF_FFFF, 6'd0);
    queue_req(kst_pkg::CMD_UPSERT, 16'hFFFF, 32'sh8000_0000, 6'd63);
    // equal scores: newest goes last, a re-upsert moves behind its peer
    queue_req(kst_pkg::CMD_UPSERT, 16'h1234, 32'sh0, 6'd0);
    queue_req(kst_pkg::CMD_UPSERT, 16'h4321, 32'sh0, 6'd0);
    queue_req(kst_pkg::CMD_UPSERT, 16'h1234, 32'sh0, 6'd0);
    for (int r = 0; r < 5; r++) begin
      queue_req(kst_pkg::CMD_READ, 16'hFFFF, 32'sh8000_0000, RANK_W'(r));
    end
    queue_req(kst_pkg::CMD_READ,   16'h0000, 32'sh0, 6'd63);
    queue_req(kst_pkg::CMD_REMOVE, 16'h4321, 32'sh0, 6'd0);
    queue_req(kst_pkg::CMD_REMOVE, 16'h4321, 32'sh0, 6'd0);
    // present id moved up to tie with the current maximum, placed behind it
    queue_req(kst_pkg::CMD_UPSERT, 16'hFFFF, 32'sh7FFF_FFFF, 6'd0);
    for (int r = 0; r < 4; r++) queue_req(kst_pkg::CMD_READ, 16'h0000, 32'sh0, RANK_W'(r));
    directed = queued;

    pool_base = ID_W'($urandom);
    while (queued < directed + RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) pool_base = ID_W'($urandom);
      seg_len = $urandom_range(20, 90);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill from a small id pool so the table runs full
          repeat (seg_len) begin
            queue_req(kst_pkg::CMD_UPSERT, pool_id(), pick_score(), RANK_W'($urandom));
          end
        end
        3: begin
          for (int i = 0; i < POOL_SPAN; i++) begin
            queue_req(kst_pkg::CMD_REMOVE, pool_base + ID_W'(i), SCORE_W'($urandom),
                      RANK_W'($urandom));
          end
        end
        4: begin
          for (int r = 0; r < CAP; r++) begin
            queue_req(kst_pkg::CMD_READ, ID_W'($urandom), SCORE_W'($urandom), RANK_W'(r));
          end
        end
        default: begin
          repeat (seg_len) begin
            pick = $urandom_range(0, 99);
            id   = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : pool_id();
            if (pick < 45) begin
              queue_req(kst_pkg::CMD_UPSERT, id, pick_score(), RANK_W'($urandom));
            end else if (pick < 70) begin
              queue_req(kst_pkg::CMD_REMOVE, id, SCORE_W'($urandom), RANK_W'($urandom));
            end else begin
              queue_req(kst_pkg::CMD_READ, ID_W'($urandom), SCORE_W'($urandom),
                        $urandom_range(0, 1) ? RANK_W'($urandom)
                                             : RANK_W'($urandom_range(0, 15)));
            end
          end
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (expected_rsps.size() != 0) begin
      err_count += expected_rsps.size();
      $display("%0d results never arrived", expected_rsps.size());
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("timeout with %0d results outstanding", expected_rsps.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
